// ===== rtl/core/convex_polygon_overlap_test_macros.svh =====
// assertion macros for the convex polygon overlap test
// no dependencies
`ifndef CONVEX_POLYGON_OVERLAP_TEST_MACROS_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTH
`define CPO_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CPO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/cpo_pkg.sv =====
// shared constants for the convex polygon overlap test
// no dependencies
package cpo_pkg;
  localparam int MAX_POINTS = 16;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LIST_W = $clog2(MAX_POINTS + 2);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_ADD = 2'd2;
  localparam logic [1:0] CMD_RUN = 2'd3;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [23:0] SCALE_ONE = 24'd65536;
  localparam logic signed [15:0] COS_ONE = 16'sd16384;
endpackage

// ===== rtl/core/convex_polygon_overlap_test.sv =====
// convex polygon overlap test by separating edges, top level
// depends on cpo_pkg and convex_polygon_overlap_test_macros.svh
//
// channel   ports                                        handshake
// command   command shape_select coord_x coord_y         start high, busy low
//           scale_factor cos_angle sin_angle closed_shape
// result    collides status                              done strobe, one cycle
//
// load commands complete in the idle state; busy stays low
// a run with an empty polygon stays idle and strobes done on the next cycle
// otherwise a run places every vertex through one shared multiply pipeline reading
// the vertex memory (read, multiply, scale, add per vertex), then walks the edges
// and, for each edge, its edge-vertex pairs, up to 2*N*(N+1) pairs
// reset needs no clearing pass; the result cannot be stalled
`include "convex_polygon_overlap_test_macros.svh"
module convex_polygon_overlap_test (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic                shape_select,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic [23:0]         scale_factor,
  input  logic signed [15:0]  cos_angle,
  input  logic signed [15:0]  sin_angle,
  input  logic                closed_shape,
  output logic                done,
  output logic                collides,
  output logic [1:0]          status
);
  localparam int IW = cpo_pkg::IDX_W;
  localparam int CW = cpo_pkg::CNT_W;
  localparam int LW = cpo_pkg::LIST_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PMUL1, S_PMUL2, S_PADD, S_EDGE_RD, S_EDGE_A, S_EDGE_B,
    S_PAIR_RD, S_PAIR_D, S_PAIR_M, S_PAIR_C
  } state_t;

  // raw vertex store
  logic [63:0] vmem [2][cpo_pkg::MAX_POINTS];
  logic [63:0] vrd;
  // placed points, one extra slot each for closure
  logic signed [31:0] pxm [2][cpo_pkg::MAX_POINTS + 1];
  logic signed [31:0] pym [2][cpo_pkg::MAX_POINTS + 1];
  logic signed [31:0] prx, pry;

  logic [CW-1:0] cnt [2];
  logic signed [31:0] offx [2], offy [2];
  logic [23:0] scl [2];
  logic signed [15:0] rc [2], rs [2];
  logic closed [2];
  logic ovf;

  state_t state;
  logic side;           // polygon being placed, or edge owner
  logic [LW-1:0] i, j;  // vertex / edge and other-vertex index
  logic signed [49:0] t1, t2, t3, t4;
  logic signed [34:0] rx, ry;
  logic signed [59:0] sx, sy;
  logic signed [31:0] ax, ay;
  logic signed [32:0] ex, ey, dx, dy;
  logic signed [65:0] m1, m2;
  logic sep;

  logic [LW-1:0] len0, len1, len_own, len_oth;
  logic [IW-1:0] vaddr;
  logic [LW-1:0] paddr;
  logic psel;
  logic signed [63:0] fx, fy;

  assign len0 = LW'(cnt[0]) + LW'(closed[0]);
  assign len1 = LW'(cnt[1]) + LW'(closed[1]);
  assign len_own = side ? len1 : len0;
  assign len_oth = side ? len0 : len1;
  assign busy = (state != S_IDLE);
  assign vaddr = (state == S_IDLE) ? cnt[shape_select][IW-1:0] : i[IW-1:0];
  assign rx = 35'((t1 - t2) >>> 14);
  assign ry = 35'((t3 + t4) >>> 14);
  assign fx = 64'(sx >>> 16) + 64'(offx[side]);
  assign fy = 64'(sy >>> 16) + 64'(offy[side]);

  always_comb begin
    psel = side;
    paddr = i;
    case (state)
      S_EDGE_RD: paddr = i;
      S_EDGE_A: paddr = i + LW'(1);
      S_PAIR_RD: begin
        psel = ~side;
        paddr = j;
      end
      default: paddr = i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && command == cpo_pkg::CMD_ADD &&
        cnt[shape_select] < CW'(cpo_pkg::MAX_POINTS)) begin
      vmem[shape_select][vaddr] <= {coord_y, coord_x};
    end
    vrd <= vmem[side][vaddr];
    prx <= pxm[psel][paddr];
    pry <= pym[psel][paddr];
    if (state == S_PADD) begin
      pxm[side][i] <= (fx > 64'sd2147483647) ? 32'sh7fffffff :
                      (fx < -64'sd2147483648) ? 32'sh80000000 : fx[31:0];
      pym[side][i] <= (fy > 64'sd2147483647) ? 32'sh7fffffff :
                      (fy < -64'sd2147483648) ? 32'sh80000000 : fy[31:0];
      if (i == '0) begin
        pxm[side][cnt[side]] <= (fx > 64'sd2147483647) ? 32'sh7fffffff :
                                (fx < -64'sd2147483648) ? 32'sh80000000 : fx[31:0];
        pym[side][cnt[side]] <= (fy > 64'sd2147483647) ? 32'sh7fffffff :
                                (fy < -64'sd2147483648) ? 32'sh80000000 : fy[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt[0] <= '0; cnt[1] <= '0;
      offx[0] <= '0; offx[1] <= '0; offy[0] <= '0; offy[1] <= '0;
      scl[0] <= cpo_pkg::SCALE_ONE; scl[1] <= cpo_pkg::SCALE_ONE;
      rc[0] <= cpo_pkg::COS_ONE; rc[1] <= cpo_pkg::COS_ONE;
      rs[0] <= '0; rs[1] <= '0;
      closed[0] <= 1'b0; closed[1] <= 1'b0;
      ovf <= 1'b0;
      side <= 1'b0;
      i <= '0; j <= '0;
      sep <= 1'b0;
      collides <= 1'b0;
      status <= cpo_pkg::STAT_OK;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          case (command)
            cpo_pkg::CMD_CLEAR: begin
              cnt[shape_select] <= '0;
              ovf <= 1'b0;
            end
            cpo_pkg::CMD_PLACE: begin
              offx[shape_select] <= coord_x;
              offy[shape_select] <= coord_y;
              scl[shape_select] <= scale_factor;
              rc[shape_select] <= cos_angle;
              rs[shape_select] <= sin_angle;
              closed[shape_select] <= closed_shape;
            end
            cpo_pkg::CMD_ADD: begin
              if (cnt[shape_select] < CW'(cpo_pkg::MAX_POINTS))
                cnt[shape_select] <= cnt[shape_select] + CW'(1);
              else
                ovf <= 1'b1;
            end
            default: begin
              if (cnt[0] == '0 || cnt[1] == '0) begin
                done <= 1'b1;
                collides <= 1'b0;
                status <= cpo_pkg::STAT_EMPTY;
              end else begin
                side <= 1'b0;
                i <= '0;
                state <= S_PRD;
              end
            end
          endcase
        end
        S_PRD: state <= S_PMUL1;  // vertex read in flight
        S_PMUL1: begin
          t1 <= 50'($signed(vrd[31:0]) * rc[side]);
          t2 <= 50'($signed(vrd[63:32]) * rs[side]);
          t3 <= 50'($signed(vrd[31:0]) * rs[side]);
          t4 <= 50'($signed(vrd[63:32]) * rc[side]);
          state <= S_PMUL2;
        end
        S_PMUL2: begin
          sx <= 60'(rx * $signed({1'b0, scl[side]}));
          sy <= 60'(ry * $signed({1'b0, scl[side]}));
          state <= S_PADD;
        end
        S_PADD: begin
          if (i + LW'(1) < LW'(cnt[side])) begin
            i <= i + LW'(1);
            state <= S_PRD;
          end else if (!side) begin
            side <= 1'b1;
            i <= '0;
            state <= S_PRD;
          end else begin
            side <= 1'b0;
            i <= '0;
            state <= S_EDGE_RD;
          end
        end
        S_EDGE_RD: begin
          if (i + LW'(1) >= len_own) begin
            if (!side) begin
              side <= 1'b1;
              i <= '0;
            end else begin
              done <= 1'b1;
              collides <= 1'b1;
              status <= ovf ? cpo_pkg::STAT_OVERFLOW : cpo_pkg::STAT_OK;
              state <= S_IDLE;
            end
          end else begin
            state <= S_EDGE_A;
          end
        end
        S_EDGE_A: begin
          ax <= prx;
          ay <= pry;
          state <= S_EDGE_B;
        end
        S_EDGE_B: begin
          ex <= 33'(prx) - 33'(ax);
          ey <= 33'(pry) - 33'(ay);
          j <= '0;
          sep <= 1'b1;
          state <= S_PAIR_RD;
        end
        S_PAIR_RD: state <= S_PAIR_D;
        S_PAIR_D: begin
          dx <= 33'(prx) - 33'(ax);
          dy <= 33'(pry) - 33'(ay);
          state <= S_PAIR_M;
        end
        S_PAIR_M: begin
          m1 <= 66'(ex) * 66'(dy);
          m2 <= 66'(ey) * 66'(dx);
          state <= S_PAIR_C;
        end
        S_PAIR_C: begin
          if (m1 < m2) begin
            // vertex inside this edge, try next edge
            i <= i + LW'(1);
            state <= S_EDGE_RD;
          end else if (j + LW'(1) < len_oth) begin
            j <= j + LW'(1);
            state <= S_PAIR_RD;
          end else begin
            done <= 1'b1;
            collides <= 1'b0;
            status <= ovf ? cpo_pkg::STAT_OVERFLOW : cpo_pkg::STAT_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPO_ASSERT_NEXT(a_run_busy, clk, rst, start && !busy && command == cpo_pkg::CMD_RUN && cnt[0] != '0 && cnt[1] != '0, busy)
  `CPO_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `CPO_ASSERT_IMPL(a_empty_status, clk, rst, done && status == cpo_pkg::STAT_EMPTY, !collides)
  `CPO_ASSERT_IMPL(a_cnt_cap, clk, rst, 1'b1, cnt[0] <= CW'(cpo_pkg::MAX_POINTS) && cnt[1] <= CW'(cpo_pkg::MAX_POINTS))
endmodule
